FILE: rtl/core/greedy_set_cover_selector_macros.svh
// Assertion macros for the greedy set cover selector checker.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef GREEDY_SET_COVER_SELECTOR_MACROS_SVH
`define GREEDY_SET_COVER_SELECTOR_MACROS_SVH

// Same-cycle implication.
`define GSCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GSCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gscs_pkg.sv
// Shared types and constants for the greedy set cover selector.
// No dependencies.
`default_nettype none

package gscs_pkg;

  localparam int CFG_W = 7;
  localparam int ID_W  = 8;
  localparam logic [CFG_W-1:0] USIZE_RST = 7'd64;

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_SCAN,
    S_COMMIT
  } state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load_en;
    logic loaded;
    logic set_used;
    logic clr_used;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/gscs_cell.sv
// One subset cell: holds a subset, scores its gain, passes the best-so-far token on.
// Depends on gscs_pkg.
`default_nettype none

module gscs_cell
  import gscs_pkg::*;
#(
  parameter int UNIVERSE_BITS = 64,
  parameter int IDX_W         = 5,
  parameter int GAIN_W        = 7,
  parameter int IDX           = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cell_ctrl_t               ctrl,
  input  wire logic [ID_W-1:0]          load_id,
  input  wire logic [UNIVERSE_BITS-1:0] load_mask,
  input  wire logic [UNIVERSE_BITS-1:0] covered,
  input  wire logic [UNIVERSE_BITS-1:0] umask,
  input  wire logic                     tin_vld,
  input  wire logic [GAIN_W-1:0]        tin_gain,
  input  wire logic [IDX_W-1:0]         tin_idx,
  input  wire logic [ID_W-1:0]          tin_id,
  input  wire logic [UNIVERSE_BITS-1:0] tin_mask,
  output logic                          tout_vld,
  output logic [GAIN_W-1:0]             tout_gain,
  output logic [IDX_W-1:0]              tout_idx,
  output logic [ID_W-1:0]               tout_id,
  output logic [UNIVERSE_BITS-1:0]      tout_mask
);

  logic [UNIVERSE_BITS-1:0] mask;
  logic [ID_W-1:0]          id;
  logic                     used;
  logic [GAIN_W-1:0]        gain;
  logic                     take;

  // strict compare keeps the earlier (lower index) subset on a tie
  assign take = ctrl.loaded && !used && (gain > tin_gain);

  always_ff @(posedge clk) begin
    if (ctrl.load_en) begin
      mask <= load_mask;
      id   <= load_id;
    end
    gain <= GAIN_W'($countones(mask & umask & ~covered));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (ctrl.clr_used || ctrl.load_en) begin
      used <= 1'b0;
    end else if (ctrl.set_used) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout_vld <= 1'b0;
    end else begin
      tout_vld <= tin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tout_gain <= gain;
      tout_idx  <= IDX_W'(IDX);
      tout_id   <= id;
      tout_mask <= mask;
    end else begin
      tout_gain <= tin_gain;
      tout_idx  <= tin_idx;
      tout_id   <= tin_id;
      tout_mask <= tin_mask;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/greedy_set_cover_selector.sv
// Greedy set cover selector: top level with sequencer, covered mask and the cell chain.
// Depends on gscs_pkg and gscs_cell.
//
// Usage:
//  - Input channel (item_valid / item_stall): one subset per transfer, carrying
//    subset_id, members and last_subset. Subsets load at one per cycle into the
//    next free cell; once MAX_SUBSETS are held, further subsets are dropped.
//  - The transfer with last_subset set starts the solve. item_stall stays high
//    until the last result of the solve has been placed in the output register.
//  - Each round clears a best-so-far token into cell 0; it moves one cell per
//    cycle and leaves the last cell with the unused subset of highest gain.
//    A round steps through round start, injection, the chain and commit.
//  - Output channel (result_valid / result_stall): one result per transfer, held
//    in a single output register. A stall holds the register and the sequencer
//    waits in its commit step; nothing is lost.
//  - Write universe_size via universe_size_we only while idle; the block won't check.
//  - Reset (rst, synchronous) empties the subset store, clears the covered mask
//    and used flags, sets universe_size to 64 and drops any pending result.
`default_nettype none

module greedy_set_cover_selector
  import gscs_pkg::*;
#(
  parameter int MAX_SUBSETS   = 32,
  parameter int UNIVERSE_BITS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration
  input  wire logic                     universe_size_we,
  input  wire logic [CFG_W-1:0]         universe_size,
  // subset input
  input  wire logic                     item_valid,
  output logic                          item_stall,
  input  wire logic [ID_W-1:0]          subset_id,
  input  wire logic [UNIVERSE_BITS-1:0] members,
  input  wire logic                     last_subset,
  // result output
  output logic                          result_valid,
  input  wire logic                     result_stall,
  output logic [ID_W-1:0]               chosen_id,
  output logic                          chosen_valid,
  output logic                          uncoverable,
  output logic                          done_res
);

  localparam int IDX_W  = (MAX_SUBSETS > 1) ? $clog2(MAX_SUBSETS) : 1;
  localparam int CNT_W  = $clog2(MAX_SUBSETS + 1);
  localparam int GAIN_W = $clog2(UNIVERSE_BITS + 1);

  state_t state, state_next;

  logic [CFG_W-1:0]         usize;
  logic [UNIVERSE_BITS-1:0] umask;
  logic [CNT_W-1:0]         count;
  logic [UNIVERSE_BITS-1:0] covered;
  logic                     inject, inject_next;

  // winner of the last scan
  logic [GAIN_W-1:0]        best_gain;
  logic [IDX_W-1:0]         best_idx;
  logic [ID_W-1:0]          best_id;
  logic [UNIVERSE_BITS-1:0] best_mask;

  // token links: index i feeds cell i, index MAX_SUBSETS is the chain exit
  logic                     lk_vld  [MAX_SUBSETS+1];
  logic [GAIN_W-1:0]        lk_gain [MAX_SUBSETS+1];
  logic [IDX_W-1:0]         lk_idx  [MAX_SUBSETS+1];
  logic [ID_W-1:0]          lk_id   [MAX_SUBSETS+1];
  logic [UNIVERSE_BITS-1:0] lk_mask [MAX_SUBSETS+1];

  cell_ctrl_t ctrl [MAX_SUBSETS];

  logic                     accept, load_we, out_free;
  logic                     covered_full;
  logic [UNIVERSE_BITS-1:0] new_cov;
  logic                     load_out, commit, finish;
  logic [ID_W-1:0]          o_id;
  logic                     o_vld, o_unc, o_done;

  // element e (bit e-1) is in the universe when e <= universe_size;
  // sizes above UNIVERSE_BITS simply give all ones
  always_comb begin
    for (int b = 0; b < UNIVERSE_BITS; b++) begin
      umask[b] = (CFG_W'(b) < usize);
    end
  end

  assign accept       = item_valid && !item_stall;
  assign load_we      = accept && (count < CNT_W'(MAX_SUBSETS));
  assign out_free     = !result_valid || !result_stall;
  assign covered_full = (covered == umask);
  assign new_cov      = covered | (best_mask & umask);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    item_stall  = 1'b1;
    inject_next = 1'b0;
    load_out    = 1'b0;
    commit      = 1'b0;
    finish      = 1'b0;
    o_id        = '0;
    o_vld       = 1'b0;
    o_unc       = 1'b0;
    o_done      = 1'b0;
    case (state)
      S_LOAD: begin
        item_stall = 1'b0;
        if (accept && last_subset) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        // nothing left to cover only happens before the first pick (empty universe)
        if (covered_full) begin
          state_next = S_COMMIT;
        end else begin
          inject_next = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (lk_vld[MAX_SUBSETS]) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (covered_full || (best_gain == '0)) begin
            // final result with no selection
            o_unc      = !covered_full;
            o_done     = 1'b1;
            finish     = 1'b1;
            state_next = S_LOAD;
          end else begin
            commit = 1'b1;
            o_id   = best_id;
            o_vld  = 1'b1;
            o_done = (new_cov == umask);
            if (new_cov == umask) begin
              finish     = 1'b1;
              state_next = S_LOAD;
            end else begin
              state_next = S_ROUND;
            end
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      usize   <= USIZE_RST;
      count   <= '0;
      covered <= '0;
      inject  <= 1'b0;
    end else begin
      inject <= inject_next;
      if (universe_size_we) begin
        usize <= universe_size;
      end
      if (finish) begin
        count <= '0;
      end else if (load_we) begin
        count <= count + 1'b1;
      end
      if (finish) begin
        covered <= '0;
      end else if (commit) begin
        covered <= new_cov;
      end
    end
  end

  // capture the token as it leaves the chain
  always_ff @(posedge clk) begin
    if (state == S_SCAN && lk_vld[MAX_SUBSETS]) begin
      best_gain <= lk_gain[MAX_SUBSETS];
      best_idx  <= lk_idx[MAX_SUBSETS];
      best_id   <= lk_id[MAX_SUBSETS];
      best_mask <= lk_mask[MAX_SUBSETS];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= load_out;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load_out) begin
      chosen_id    <= o_id;
      chosen_valid <= o_vld;
      uncoverable  <= o_unc;
      done_res     <= o_done;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  // empty token: gain zero, so only a subset that adds coverage can win
  assign lk_vld[0]  = inject;
  assign lk_gain[0] = '0;
  assign lk_idx[0]  = '0;
  assign lk_id[0]   = '0;
  assign lk_mask[0] = '0;

  for (genvar i = 0; i < MAX_SUBSETS; i++) begin : g_cell
    assign ctrl[i].load_en  = load_we && (count[IDX_W-1:0] == IDX_W'(i));
    assign ctrl[i].loaded   = (CNT_W'(i) < count);
    assign ctrl[i].set_used = commit && (best_idx == IDX_W'(i));
    assign ctrl[i].clr_used = finish;

    gscs_cell #(
      .UNIVERSE_BITS (UNIVERSE_BITS),
      .IDX_W         (IDX_W),
      .GAIN_W        (GAIN_W),
      .IDX           (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl[i]),
      .load_id   (subset_id),
      .load_mask (members),
      .covered   (covered),
      .umask     (umask),
      .tin_vld   (lk_vld[i]),
      .tin_gain  (lk_gain[i]),
      .tin_idx   (lk_idx[i]),
      .tin_id    (lk_id[i]),
      .tin_mask  (lk_mask[i]),
      .tout_vld  (lk_vld[i+1]),
      .tout_gain (lk_gain[i+1]),
      .tout_idx  (lk_idx[i+1]),
      .tout_id   (lk_id[i+1]),
      .tout_mask (lk_mask[i+1])
    );
  end

endmodule

`default_nettype wire

FILE: rtl/core/gscs_checker.sv
// Port-level checker for the greedy set cover selector, bound to the top level.
// Depends on gscs_pkg and greedy_set_cover_selector_macros.svh.
`default_nettype none

`include "greedy_set_cover_selector_macros.svh"

module gscs_checker
  import gscs_pkg::*;
(
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            item_valid,
  input wire logic            item_stall,
  input wire logic            last_subset,
  input wire logic            result_valid,
  input wire logic            result_stall,
  input wire logic [ID_W-1:0] chosen_id,
  input wire logic            chosen_valid,
  input wire logic            uncoverable,
  input wire logic            done_res
);

  `GSCS_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid && $stable(chosen_id) && $stable(done_res), "stalled result changed")

  `GSCS_ASSERT_NEXT(a_solve_stalls, item_valid && !item_stall && last_subset, item_stall, "input not stalled after last subset")

  `GSCS_ASSERT_NOW(a_nosel_final, result_valid && !chosen_valid, done_res && (chosen_id == '0), "no-selection result is not final")

  `GSCS_ASSERT_NOW(a_unc_nosel, result_valid && uncoverable, !chosen_valid, "uncoverable flagged on a selection")

endmodule

bind greedy_set_cover_selector gscs_checker u_gscs_checker (.*);

`default_nettype wire
